@@ rtl/core/ppc_pkg.sv @@
// ----------------------------------------------------------------------------
// pH probe conversion package
// Shared widths, constants, register codes and inter-module structs.
// ----------------------------------------------------------------------------
package ppc_pkg;

  // Converter resolution and full-scale code.
  localparam int ADC_BITS = 12;
  localparam int FS       = (1 << ADC_BITS) - 1;

  // Field widths.
  localparam int PH_W   = 14;
  localparam int VOLT_W = 16;
  localparam int TEMP_W = 15;
  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;
  localparam int Q_W    = 14;

  // Fixed-point constants: kelvin offset in 0.01 K and the pH ceiling.
  localparam int KELVIN_OFS = 27315;
  localparam int PH_MAX     = 14000;
  localparam int ADC_GAIN   = 99000;

  // Register reset values.
  localparam int PH_A_RST = 4000;
  localparam int PH_B_RST = 7000;
  localparam int PH_C_RST = 10000;
  localparam int TEMP_RST = 2500;

  // Datapath widths (all signed unless noted).
  localparam int D_W   = ADC_BITS + 2;
  localparam int TK_W  = 17;
  localparam int SP_W  = 18;
  localparam int SV_W  = 18;
  localparam int SPP_W = 32;
  localparam int SPV_W = 32;
  localparam int DD_W  = 34;
  localparam int NN_W  = 36;
  localparam int AV_W  = 52;
  localparam int BV_W  = DD_W + D_W;
  localparam int YA_W  = NN_W + ADC_BITS + 3;
  localparam int X_W   = AV_W + ADC_BITS + 2;
  localparam int Y_W   = YA_W + TK_W;
  localparam int XL_W  = X_W / 2;
  localparam int XH_W  = X_W - XL_W;
  localparam int PL_W  = XL_W + 1 + TK_W;
  localparam int PHI_W = XH_W + TK_W;
  localparam int XT_W  = X_W + TK_W;
  // Divider working width: holds 2|X|+|Y| and the divisor shifted by Q_W.
  localparam int R_W   = (XT_W + 2 > Y_W + Q_W + 2) ? XT_W + 2 : Y_W + Q_W + 2;

  // Configuration register codes (word index).
  typedef enum logic [2:0] {
    REG_VOLT_A = 3'd0,
    REG_PH_A   = 3'd1,
    REG_VOLT_B = 3'd2,
    REG_PH_B   = 3'd3,
    REG_VOLT_C = 3'd4,
    REG_PH_C   = 3'd5,
    REG_TEMP   = 3'd6
  } reg_idx_t;

  // Calibration register set.
  typedef struct packed {
    logic [VOLT_W-1:0] volt_a;
    logic [PH_W-1:0]   ph_a;
    logic [VOLT_W-1:0] volt_b;
    logic [PH_W-1:0]   ph_b;
    logic [VOLT_W-1:0] volt_c;
    logic [PH_W-1:0]   ph_c;
    logic [TEMP_W-1:0] temp;
  } cal_t;

  // Front end to divider: magnitudes and outcome flags.
  typedef struct packed {
    logic            bad;
    logic            zero;
    logic [XT_W-1:0] xmag;
    logic [Y_W-1:0]  ymag;
  } mag_t;

  // Divider to output stage.
  typedef struct packed {
    logic           bad;
    logic           zero;
    logic           hi;
    logic [Q_W-1:0] q;
  } quo_t;

endpackage

@@ rtl/core/ppc_in_if.sv @@
// ----------------------------------------------------------------------------
// pH probe input channel
// Valid/ready channel carrying one converter sample and a temperature.
// ----------------------------------------------------------------------------
interface ppc_in_if;
  logic                          valid;
  logic                          ready;
  logic [ppc_pkg::ADC_BITS-1:0]  adc_sample;
  logic [ppc_pkg::TEMP_W-1:0]    water_temp;
  logic                          temp_valid;

  modport source (output valid, output adc_sample, output water_temp,
                  output temp_valid, input ready);
  modport sink   (input valid, input adc_sample, input water_temp,
                  input temp_valid, output ready);
endinterface

@@ rtl/core/ppc_out_if.sv @@
// ----------------------------------------------------------------------------
// pH probe result channel
// Valid/ready channel carrying one pH reading and its valid flag.
// ----------------------------------------------------------------------------
interface ppc_out_if;
  logic                     valid;
  logic                     ready;
  logic [ppc_pkg::PH_W-1:0] ph_value;
  logic                     ph_valid;

  modport source (output valid, output ph_value, output ph_valid, input ready);
  modport sink   (input valid, input ph_value, input ph_valid, output ready);
endinterface

@@ rtl/core/ph_probe_conversion.sv @@
// ----------------------------------------------------------------------------
// pH probe conversion
// Converts a raw probe sample into temperature-compensated pH using a
// three-point least-squares calibration.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one beat per sample: adc_sample, water_temp and
//   temp_valid (when low the calibration temperature is used instead).
//   out_ch returns one beat per sample, in order: ph_value in 0.001 pH,
//   clamped to 0..14000, and ph_valid, low for a degenerate calibration.
//   The calibration points and temperature are written over the APB port
//   at word addresses 0..6; write them only while no samples are in flight.
// Pipeline:
//   A sample loads the first of seven front-end stages at the edge that
//   takes it, then passes fifteen divider stages (a setup stage, then one
//   quotient bit each) and the output register. One sample is accepted
//   per cycle unless a stall of out_ch has filled the pipeline.
// Reset and stalls:
//   Reset empties the pipeline and loads the default calibration
//   (0 V at pH 4, 7 and 10, 25.00 C). When out_ch is stalled the output
//   register holds and beats behind it move up only into empty stages,
//   so in_ch stays ready until the pipeline is full.
// ----------------------------------------------------------------------------
module ph_probe_conversion (
  input  logic                       clk,
  input  logic                       rst_n,
  ppc_in_if.sink                     in_ch,
  ppc_out_if.source                  out_ch,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppc_pkg::ADDR_W-1:0] paddr,
  input  logic [ppc_pkg::DATA_W-1:0] pwdata,
  output logic [ppc_pkg::DATA_W-1:0] prdata,
  output logic                       pready
);

  ppc_pkg::cal_t cal;
  ppc_pkg::mag_t mag;
  ppc_pkg::quo_t quo;
  logic          mag_vld, mag_rdy;
  logic          quo_vld;
  logic          out_en;

  logic                     out_vld_r;
  logic [ppc_pkg::PH_W-1:0] ph_value_r, ph_value_nxt;
  logic                     ph_valid_r, ph_valid_nxt;

  ppc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cal     (cal)
  );

  ppc_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cal     (cal),
    .in_ch   (in_ch),
    .mag_vld (mag_vld),
    .mag_rdy (mag_rdy),
    .mag     (mag)
  );

  ppc_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .mag_vld (mag_vld),
    .mag_rdy (mag_rdy),
    .mag     (mag),
    .quo_vld (quo_vld),
    .quo_rdy (out_en),
    .quo     (quo)
  );

  // Output register loads when empty or when its beat is taken.
  assign out_en = ~out_vld_r | out_ch.ready;

  // Final selection: invalid, negative, overflow or rounded quotient.
  always_comb begin
    if (quo.bad) begin
      ph_value_nxt = '0;
      ph_valid_nxt = 1'b0;
    end else if (quo.zero) begin
      ph_value_nxt = '0;
      ph_valid_nxt = 1'b1;
    end else if (quo.hi || (quo.q > ppc_pkg::Q_W'(ppc_pkg::PH_MAX))) begin
      ph_value_nxt = ppc_pkg::PH_W'(ppc_pkg::PH_MAX);
      ph_valid_nxt = 1'b1;
    end else begin
      ph_value_nxt = quo.q;
      ph_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= quo_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      ph_value_r <= ph_value_nxt;
      ph_valid_r <= ph_valid_nxt;
    end
  end

  assign out_ch.valid    = out_vld_r;
  assign out_ch.ph_value = ph_value_r;
  assign out_ch.ph_valid = ph_valid_r;

endmodule

@@ rtl/core/ppc_cfg.sv @@
// ----------------------------------------------------------------------------
// pH probe calibration registers
// APB-style register file holding the three calibration points and the
// calibration temperature.
// ----------------------------------------------------------------------------
module ppc_cfg (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [ppc_pkg::ADDR_W-1:0] paddr,
  input  logic [ppc_pkg::DATA_W-1:0] pwdata,
  output logic [ppc_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output ppc_pkg::cal_t              cal
);

  logic              wr_en;
  ppc_pkg::reg_idx_t idx;
  ppc_pkg::cal_t     cal_r;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = ppc_pkg::reg_idx_t'(paddr[ppc_pkg::ADDR_W-1:2]);
  assign pready = 1'b1;
  assign cal    = cal_r;

  // Register writes; unmapped addresses are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r.volt_a <= '0;
      cal_r.ph_a   <= ppc_pkg::PH_W'(ppc_pkg::PH_A_RST);
      cal_r.volt_b <= '0;
      cal_r.ph_b   <= ppc_pkg::PH_W'(ppc_pkg::PH_B_RST);
      cal_r.volt_c <= '0;
      cal_r.ph_c   <= ppc_pkg::PH_W'(ppc_pkg::PH_C_RST);
      cal_r.temp   <= ppc_pkg::TEMP_W'(ppc_pkg::TEMP_RST);
    end else if (wr_en) begin
      case (idx)
        ppc_pkg::REG_VOLT_A: cal_r.volt_a <= pwdata[ppc_pkg::VOLT_W-1:0];
        ppc_pkg::REG_PH_A:   cal_r.ph_a   <= pwdata[ppc_pkg::PH_W-1:0];
        ppc_pkg::REG_VOLT_B: cal_r.volt_b <= pwdata[ppc_pkg::VOLT_W-1:0];
        ppc_pkg::REG_PH_B:   cal_r.ph_b   <= pwdata[ppc_pkg::PH_W-1:0];
        ppc_pkg::REG_VOLT_C: cal_r.volt_c <= pwdata[ppc_pkg::VOLT_W-1:0];
        ppc_pkg::REG_PH_C:   cal_r.ph_c   <= pwdata[ppc_pkg::PH_W-1:0];
        ppc_pkg::REG_TEMP:   cal_r.temp   <= pwdata[ppc_pkg::TEMP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Read mux returns the raw register bits.
  always_comb begin
    case (idx)
      ppc_pkg::REG_VOLT_A: prdata = ppc_pkg::DATA_W'(cal_r.volt_a);
      ppc_pkg::REG_PH_A:   prdata = ppc_pkg::DATA_W'(cal_r.ph_a);
      ppc_pkg::REG_VOLT_B: prdata = ppc_pkg::DATA_W'(cal_r.volt_b);
      ppc_pkg::REG_PH_B:   prdata = ppc_pkg::DATA_W'(cal_r.ph_b);
      ppc_pkg::REG_VOLT_C: prdata = ppc_pkg::DATA_W'(cal_r.volt_c);
      ppc_pkg::REG_PH_C:   prdata = ppc_pkg::DATA_W'(cal_r.ph_c);
      ppc_pkg::REG_TEMP:   prdata = ppc_pkg::DATA_W'(cal_r.temp);
      default:             prdata = '0;
    endcase
  end

endmodule

@@ rtl/core/ppc_front.sv @@
// ----------------------------------------------------------------------------
// pH probe front end
// Seven-stage pipeline that fits the calibration line, forms the numerator
// and denominator of the pH quotient and hands over their magnitudes.
// ----------------------------------------------------------------------------
module ppc_front (
  input  logic          clk,
  input  logic          rst_n,
  input  ppc_pkg::cal_t cal,
  ppc_in_if.sink        in_ch,
  output logic          mag_vld,
  input  logic          mag_rdy,
  output ppc_pkg::mag_t mag
);

  localparam int NS = 7;

  logic [NS-1:0] vld_r;
  logic [NS:0]   en;

  // Stage enables: a stage loads when it is empty or its successor loads.
  assign en[NS] = mag_rdy;
  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = ~vld_r[s] | en[s+1];
  end

  assign in_ch.ready = en[0];
  assign mag_vld     = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= in_ch.valid;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  // Stage 1: sample offset, temperatures in kelvin and calibration sums.
  logic signed [ppc_pkg::PH_W:0]       p0, p1, p2;
  logic signed [ppc_pkg::VOLT_W-1:0]   v0, v1, v2;
  logic        [ppc_pkg::TEMP_W-1:0]   tsel;
  logic signed [ppc_pkg::D_W-1:0]      d1_r;
  logic signed [ppc_pkg::TK_W-1:0]     tw1_r, tc1_r;
  logic signed [ppc_pkg::SP_W-1:0]     sp1_r;
  logic signed [ppc_pkg::SV_W-1:0]     sv1_r;
  logic signed [ppc_pkg::SPP_W-1:0]    spp1_r;
  logic signed [ppc_pkg::SPV_W-1:0]    spv1_r;

  assign p0   = $signed({1'b0, cal.ph_a});
  assign p1   = $signed({1'b0, cal.ph_b});
  assign p2   = $signed({1'b0, cal.ph_c});
  assign v0   = $signed(cal.volt_a);
  assign v1   = $signed(cal.volt_b);
  assign v2   = $signed(cal.volt_c);
  assign tsel = in_ch.temp_valid ? in_ch.water_temp : cal.temp;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      d1_r   <= ppc_pkg::D_W'($signed({1'b0, in_ch.adc_sample, 1'b0}) - ppc_pkg::FS);
      tw1_r  <= ppc_pkg::TK_W'($signed(tsel) + ppc_pkg::KELVIN_OFS);
      tc1_r  <= ppc_pkg::TK_W'($signed(cal.temp) + ppc_pkg::KELVIN_OFS);
      sp1_r  <= ppc_pkg::SP_W'(p0) + ppc_pkg::SP_W'(p1) + ppc_pkg::SP_W'(p2);
      sv1_r  <= ppc_pkg::SV_W'(v0) + ppc_pkg::SV_W'(v1) + ppc_pkg::SV_W'(v2);
      spp1_r <= p0 * p0 + p1 * p1 + p2 * p2;
      spv1_r <= p0 * v0 + p1 * v1 + p2 * v2;
    end
  end

  // Stage 2: fit denominator, fit numerator and the voltage range check.
  logic signed [ppc_pkg::DD_W-1:0] dd2_r;
  logic signed [ppc_pkg::NN_W-1:0] nn2_r;
  logic                            ovr2_r;
  logic signed [ppc_pkg::D_W-1:0]  d2_r;
  logic signed [ppc_pkg::TK_W-1:0] tw2_r, tc2_r;
  logic signed [ppc_pkg::SP_W-1:0] sp2_r;
  logic signed [ppc_pkg::SV_W-1:0] sv2_r;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dd2_r  <= 3 * spp1_r - sp1_r * sp1_r;
      nn2_r  <= 3 * spv1_r - sp1_r * sv1_r;
      ovr2_r <= (d1_r < 0) ? (-33 * d1_r > 50 * ppc_pkg::FS)
                           : (33 * d1_r > 50 * ppc_pkg::FS);
      d2_r   <= d1_r;
      tw2_r  <= tw1_r;
      tc2_r  <= tc1_r;
      sp2_r  <= sp1_r;
      sv2_r  <= sv1_r;
    end
  end

  // Stage 3: the products that feed numerator and denominator.
  logic signed [ppc_pkg::AV_W-1:0] av3_r;
  logic signed [ppc_pkg::BV_W-1:0] bv3_r;
  logic signed [ppc_pkg::YA_W-1:0] ya3_r;
  logic                            bad3_r;
  logic signed [ppc_pkg::TK_W-1:0] tw3_r, tc3_r;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      av3_r  <= sv2_r * dd2_r + nn2_r * sp2_r;
      bv3_r  <= dd2_r * d2_r;
      ya3_r  <= nn2_r * (6 * ppc_pkg::FS);
      bad3_r <= ovr2_r || (dd2_r == 0) || (nn2_r == 0);
      tw3_r  <= tw2_r;
      tc3_r  <= tc2_r;
    end
  end

  // Stage 4: numerator before temperature and the full denominator.
  logic signed [ppc_pkg::X_W-1:0]  x4_r;
  logic signed [ppc_pkg::Y_W-1:0]  y4_r;
  logic                            bad4_r;
  logic signed [ppc_pkg::TK_W-1:0] tc4_r;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      x4_r   <= (2 * ppc_pkg::FS) * av3_r + ppc_pkg::ADC_GAIN * bv3_r;
      y4_r   <= ya3_r * tw3_r;
      bad4_r <= bad3_r;
      tc4_r  <= tc3_r;
    end
  end

  // Stage 5: numerator times calibration kelvin, as two partial products.
  logic signed [ppc_pkg::XL_W:0]    xl_s;
  logic signed [ppc_pkg::XH_W-1:0]  xh_s;
  logic signed [ppc_pkg::PL_W-1:0]  xlo5_r;
  logic signed [ppc_pkg::PHI_W-1:0] xhi5_r;
  logic signed [ppc_pkg::Y_W-1:0]   y5_r;
  logic                             bad5_r;

  assign xl_s = $signed({1'b0, x4_r[ppc_pkg::XL_W-1:0]});
  assign xh_s = $signed(x4_r[ppc_pkg::X_W-1:ppc_pkg::XL_W]);

  always_ff @(posedge clk) begin
    if (en[4]) begin
      xlo5_r <= xl_s * tc4_r;
      xhi5_r <= xh_s * tc4_r;
      y5_r   <= y4_r;
      bad5_r <= bad4_r;
    end
  end

  // Stage 6: combine the partial products.
  logic signed [ppc_pkg::XT_W-1:0] xt6_r;
  logic signed [ppc_pkg::Y_W-1:0]  y6_r;
  logic                            bad6_r;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      xt6_r  <= (ppc_pkg::XT_W'(xhi5_r) <<< ppc_pkg::XL_W) + ppc_pkg::XT_W'(xlo5_r);
      y6_r   <= y5_r;
      bad6_r <= bad5_r;
    end
  end

  // Stage 7: signs and magnitudes. Opposite nonzero signs give a zero pH.
  logic          xneg, yneg;
  ppc_pkg::mag_t mag_nxt, mag_r;

  assign xneg = xt6_r[ppc_pkg::XT_W-1];
  assign yneg = y6_r[ppc_pkg::Y_W-1];

  always_comb begin
    mag_nxt.bad  = bad6_r;
    mag_nxt.zero = (xt6_r != 0) && (xneg != yneg);
    mag_nxt.xmag = xneg ? -xt6_r : xt6_r;
    mag_nxt.ymag = yneg ? -y6_r : y6_r;
  end

  always_ff @(posedge clk) begin
    if (en[6]) begin
      mag_r <= mag_nxt;
    end
  end

  assign mag = mag_r;

endmodule

@@ rtl/core/ppc_div.sv @@
// ----------------------------------------------------------------------------
// pH probe quotient pipeline
// Rounded restoring division, one quotient bit per stage after a setup stage,
// with detection of quotients at or above the 14-bit ceiling.
// ----------------------------------------------------------------------------
module ppc_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          mag_vld,
  output logic          mag_rdy,
  input  ppc_pkg::mag_t mag,
  output logic          quo_vld,
  input  logic          quo_rdy,
  output ppc_pkg::quo_t quo
);

  localparam int NS = ppc_pkg::Q_W + 1;

  logic [NS-1:0]             vld_r;
  logic [NS:0]               en;
  logic [ppc_pkg::R_W-1:0]   rem_r [NS];
  logic [ppc_pkg::R_W-1:0]   dvs_r [NS];
  logic [ppc_pkg::Q_W-1:0]   q_r   [NS];
  logic                      bad_r [NS];
  logic                      zero_r[NS];
  logic                      hi_r  [NS];

  // Stage enables, loaded when empty or when the successor loads.
  assign en[NS] = quo_rdy;
  for (genvar s = 0; s < NS; s++) begin : g_en
    assign en[s] = ~vld_r[s] | en[s+1];
  end

  assign mag_rdy = en[0];
  assign quo_vld = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (en[0]) begin
        vld_r[0] <= mag_vld;
      end
      for (int s = 1; s < NS; s++) begin
        if (en[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
      end
    end
  end

  // Setup: remainder 2|X|+|Y| and divisor 2|Y| give rounding to nearest.
  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem_r[0]  <= (ppc_pkg::R_W'(mag.xmag) << 1) + ppc_pkg::R_W'(mag.ymag);
      dvs_r[0]  <= ppc_pkg::R_W'(mag.ymag) << 1;
      q_r[0]    <= '0;
      bad_r[0]  <= mag.bad;
      zero_r[0] <= mag.zero;
      hi_r[0]   <= 1'b0;
    end
  end

  // One quotient bit per stage, most significant first.
  for (genvar s = 1; s < NS; s++) begin : g_step
    localparam int K = ppc_pkg::Q_W - s;

    logic [ppc_pkg::R_W-1:0] shd;
    logic                    ge;

    assign shd = dvs_r[s-1] << K;
    assign ge  = rem_r[s-1] >= shd;

    always_ff @(posedge clk) begin
      if (en[s]) begin
        rem_r[s]  <= ge ? rem_r[s-1] - shd : rem_r[s-1];
        dvs_r[s]  <= dvs_r[s-1];
        q_r[s]    <= q_r[s-1] | (ppc_pkg::Q_W'(ge) << K);
        bad_r[s]  <= bad_r[s-1];
        zero_r[s] <= zero_r[s-1];
        // The first quotient-bit stage also checks whether the quotient overflows.
        if (s == 1) begin
          hi_r[s] <= hi_r[s-1] | (rem_r[s-1] >= (dvs_r[s-1] << ppc_pkg::Q_W));
        end else begin
          hi_r[s] <= hi_r[s-1];
        end
      end
    end
  end

  assign quo.bad  = bad_r[NS-1];
  assign quo.zero = zero_r[NS-1];
  assign quo.hi   = hi_r[NS-1];
  assign quo.q    = q_r[NS-1];

endmodule

@@ rtl/core/ppc_checker.sv @@
// ----------------------------------------------------------------------------
// pH probe port checker
// Port-level assertions on the conversion block, attached by bind.
// ----------------------------------------------------------------------------
module ppc_checker (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [ppc_pkg::PH_W-1:0] ph_value,
  input logic                     ph_valid
);

  // Reset empties the result register.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result beat shown right after reset");

  // With no result waiting, the pipeline is never full.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input not ready while output stage is empty");

  // A stalled result beat holds.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(ph_value) && $stable(ph_valid))
    else $error("stalled result beat changed");

  // Results stay within the pH range.
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ph_value <= ppc_pkg::PH_W'(ppc_pkg::PH_MAX))
    else $error("pH value above ceiling");

  // An invalid result carries a zero value.
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !ph_valid |-> ph_value == '0)
    else $error("invalid result with nonzero value");

endmodule

bind ph_probe_conversion ppc_checker u_ppc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .ph_value  (out_ch.ph_value),
  .ph_valid  (out_ch.ph_valid)
);
